// File: hw/rtl/bba_pkg.sv
// Shared widths, codes and defaults of the bitmap buffer allocator.
package bba_pkg;

  localparam int BUFFERS_DEF = 1024;

  localparam int OP_W     = 2;
  localparam int SIZE_W   = 32;
  localparam int CNT_W    = 11;
  localparam int ADDR_W   = 48;
  localparam int STAT_W   = 3;
  localparam int SLOT_W   = 10;
  localparam int WORD_W   = 32;
  localparam int WORD_SH  = 5;
  localparam int PROD_W   = CNT_W + SIZE_W;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 64;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ADDR_W;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES  = 3'd4;

  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_REGION = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_ZERO    = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOPOOL  = 3'd2;
  localparam logic [STAT_W-1:0] ST_REGION  = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;
  localparam logic [STAT_W-1:0] ST_NULL    = 3'd5;
  localparam logic [STAT_W-1:0] ST_OUTSIDE = 3'd6;

endpackage

// File: hw/rtl/bitmap_buffer_allocator_unit.sv
// Allocations scan 32-bit map words, 1 to BUFFERS/32 of them, for the lowest free bit.
// Throughput: one item at a time; the map scan at one RAM word a cycle and the
//   bit-serial divider bound it. The output register lets the next item start
//   while a result waits.
// Reset: synchronous; a clearing pass writes all ceil(BUFFERS/32) map words to zero
//   (32 words at the default size) with in_tready low; config writes are taken.
module bitmap_buffer_allocator_unit #(
  parameter int BUFFERS = bba_pkg::BUFFERS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request_size[31:0], region_index[42:32], region_count[53:43],
  // release_address[101:54], zero pad
  input  logic [bba_pkg::IN_TDATA_W-1:0]  in_tdata,
  // operation[1:0]
  input  logic [bba_pkg::OP_W-1:0]        in_tuser,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // granted_address[47:0], slot_index[57:48], zero pad
  output logic [bba_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status[2:0]
  output logic [bba_pkg::STAT_W-1:0]      out_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bba_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import bba_pkg::*;

  localparam int WORDS = (BUFFERS + WORD_W - 1) / WORD_W;
  localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int WP_W  = CNT_W - WORD_SH;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_RANGE_MUL, S_RANGE, S_DIV, S_LO_MUL, S_BOUNDS,
    S_SCAN_RD, S_SCAN_CHK, S_GNT_MUL, S_GNT_ADDR, S_FREE_RD, S_FREE_WR, S_DONE
  } state_t;

  // configuration
  logic              en_r;
  logic [ADDR_W-1:0] base_r;
  logic [SIZE_W-1:0] stride_r;
  logic [CNT_W-1:0]  count_r;
  logic [SIZE_W-1:0] bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r     <= 1'b0;
      base_r   <= '0;
      stride_r <= SIZE_W'(1);
      count_r  <= '0;
      bytes_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE: en_r     <= cfg_wdata[0];
        REG_BASE:   base_r   <= cfg_wdata[ADDR_W-1:0];
        REG_STRIDE: stride_r <= cfg_wdata[SIZE_W-1:0];
        REG_COUNT:  count_r  <= cfg_wdata[CNT_W-1:0];
        REG_BYTES:  bytes_r  <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] cnt;
  assign cnt = (32'(count_r) > BUFFERS) ? CNT_W'(BUFFERS) : count_r;

  // state and item registers
  state_t            state_r, state_nxt;
  logic [WA_W-1:0]   clr_r, clr_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [CNT_W-1:0]  ridx_r, ridx_nxt;
  logic [CNT_W-1:0]  rnum_r, rnum_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [CNT_W-1:0]  per_r, per_nxt;
  logic [CNT_W-1:0]  lo_r, lo_nxt;
  logic [CNT_W-1:0]  hi_r, hi_nxt;
  logic [WP_W-1:0]   wp_r, wp_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [STAT_W-1:0] res_st_r, res_st_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_st_r, out_st_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;

  // map RAM port
  logic              mem_we, mem_re;
  logic [WA_W-1:0]   mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;

  bba_bitmap #(.WORDS(WORDS), .WA_W(WA_W)) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // shared divider
  logic              div_start, div_busy, div_done;
  logic [ADDR_W-1:0] div_dividend;
  logic [SIZE_W-1:0] div_divisor;
  logic [CNT_W-1:0]  div_q;

  bba_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // word scan: free bits inside [lo, hi), lowest one
  logic [WORD_W-1:0]  free_vec, free_oh;
  logic [WORD_SH-1:0] free_pos;
  logic               free_any;
  logic [WP_W-1:0]    last_wp;
  logic [CNT_W-1:0]   hi_m1;

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      free_vec[b] = !mem_rdata[b] && ({wp_r, WORD_SH'(b)} >= lo_r)
                    && ({wp_r, WORD_SH'(b)} < hi_r);
    end
    free_oh  = free_vec & (~free_vec + WORD_W'(1));
    free_any = |free_vec;
    free_pos = '0;
    for (int k = 0; k < WORD_SH; k++) begin
      for (int b = 0; b < WORD_W; b++) begin
        if (((b >> k) & 1) == 1) begin
          free_pos[k] = free_pos[k] | free_oh[b];
        end
      end
    end
  end

  assign hi_m1   = hi_r - CNT_W'(1);
  assign last_wp = hi_m1[CNT_W-1:WORD_SH];

  // shared multiplier operands
  logic [CNT_W-1:0]  mul_a;
  logic [SIZE_W-1:0] mul_b;
  logic              fits;
  logic [ADDR_W:0]   range_end;
  logic              out_load;

  assign fits      = en_r && (bytes_r >= size_r);
  assign range_end = {1'b0, base_r} + (ADDR_W + 1)'(prod_r);
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    unique case (state_r)
      S_RANGE_MUL: mul_a = cnt - CNT_W'(1);
      S_LO_MUL:    mul_a = ridx_r;
      default:     mul_a = idx_r;
    endcase
    mul_b = (state_r == S_LO_MUL) ? SIZE_W'(per_r) : stride_r;
  end

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    op_nxt       = op_r;
    size_nxt     = size_r;
    ridx_nxt     = ridx_r;
    rnum_nxt     = rnum_r;
    addr_nxt     = addr_r;
    per_nxt      = per_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    wp_nxt       = wp_r;
    idx_nxt      = idx_r;
    prod_nxt     = prod_r;
    res_st_nxt   = res_st_r;
    res_addr_nxt = res_addr_r;
    res_slot_nxt = res_slot_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_st_nxt   = out_st_r;
    out_addr_nxt = out_addr_r;
    out_slot_nxt = out_slot_r;
    mem_we       = 1'b0;
    mem_waddr    = WA_W'(wp_r);
    mem_wdata    = mem_rdata | free_oh;
    mem_re       = 1'b0;
    mem_raddr    = WA_W'(wp_r);
    div_start    = 1'b0;
    div_dividend = addr_r - base_r;
    div_divisor  = (stride_r == '0) ? SIZE_W'(1) : stride_r;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + WA_W'(1);
        if (clr_r == WA_W'(WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          size_nxt  = in_tdata[31:0];
          ridx_nxt  = in_tdata[42:32];
          rnum_nxt  = in_tdata[53:43];
          addr_nxt  = in_tdata[101:54];
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        res_st_nxt   = ST_OK;
        res_addr_nxt = '0;
        res_slot_nxt = '0;
        state_nxt    = S_DONE;
        case (op_r)
          OP_ALLOC: begin
            if (size_r == '0) begin
              res_st_nxt = ST_ZERO;
            end else if (!fits) begin
              res_st_nxt = ST_NOPOOL;
            end else if (cnt == '0) begin
              res_st_nxt = ST_FULL;
            end else begin
              lo_nxt    = '0;
              hi_nxt    = cnt;
              wp_nxt    = '0;
              state_nxt = S_SCAN_RD;
            end
          end
          OP_REGION: begin
            if (size_r == '0) begin
              res_st_nxt = ST_ZERO;
            end else if (ridx_r >= rnum_r) begin
              res_st_nxt = ST_REGION;
            end else if (!fits) begin
              res_st_nxt = ST_NOPOOL;
            end else if (rnum_r > cnt) begin
              res_st_nxt = ST_REGION;
            end else begin
              div_start    = 1'b1;
              div_dividend = ADDR_W'(cnt);
              div_divisor  = SIZE_W'(rnum_r);
              state_nxt    = S_DIV;
            end
          end
          OP_FREE: begin
            if (addr_r == '0) begin
              res_st_nxt = ST_NULL;
            end else if (!en_r || cnt == '0) begin
              res_st_nxt = ST_OUTSIDE;
            end else begin
              state_nxt = S_RANGE_MUL;
            end
          end
          default: ;
        endcase
      end
      S_RANGE_MUL: begin
        prod_nxt  = PROD_W'(mul_a) * PROD_W'(mul_b);
        state_nxt = S_RANGE;
      end
      S_RANGE: begin
        if (addr_r < base_r || {1'b0, addr_r} > range_end) begin
          res_st_nxt = ST_OUTSIDE;
          state_nxt  = S_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (op_r == OP_REGION) begin
            per_nxt   = div_q;
            state_nxt = S_LO_MUL;
          end else begin
            idx_nxt   = div_q;
            state_nxt = S_FREE_RD;
          end
        end
      end
      S_LO_MUL: begin
        prod_nxt  = PROD_W'(mul_a) * PROD_W'(mul_b);
        state_nxt = S_BOUNDS;
      end
      S_BOUNDS: begin
        lo_nxt    = prod_r[CNT_W-1:0];
        hi_nxt    = prod_r[CNT_W-1:0] + per_r;
        wp_nxt    = prod_r[CNT_W-1:WORD_SH];
        state_nxt = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (free_any) begin
          // mark the buffer taken in the word just read
          mem_we    = 1'b1;
          idx_nxt   = {wp_r, free_pos};
          state_nxt = S_GNT_MUL;
        end else if (wp_r == last_wp) begin
          res_st_nxt = ST_FULL;
          state_nxt  = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = WA_W'(wp_r + WP_W'(1));
          wp_nxt    = wp_r + WP_W'(1);
        end
      end
      S_GNT_MUL: begin
        prod_nxt  = PROD_W'(mul_a) * PROD_W'(mul_b);
        state_nxt = S_GNT_ADDR;
      end
      S_GNT_ADDR: begin
        res_addr_nxt = base_r + ADDR_W'(prod_r);
        res_slot_nxt = idx_r[SLOT_W-1:0];
        state_nxt    = S_DONE;
      end
      S_FREE_RD: begin
        mem_re    = 1'b1;
        mem_raddr = WA_W'(idx_r[CNT_W-1:WORD_SH]);
        state_nxt = S_FREE_WR;
      end
      S_FREE_WR: begin
        mem_we       = 1'b1;
        mem_waddr    = WA_W'(idx_r[CNT_W-1:WORD_SH]);
        mem_wdata    = mem_rdata & ~(WORD_W'(1) << idx_r[WORD_SH-1:0]);
        res_slot_nxt = idx_r[SLOT_W-1:0];
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_addr_nxt  = res_addr_r;
          out_slot_nxt  = res_slot_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    size_r     <= size_nxt;
    ridx_r     <= ridx_nxt;
    rnum_r     <= rnum_nxt;
    addr_r     <= addr_nxt;
    per_r      <= per_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    wp_r       <= wp_nxt;
    idx_r      <= idx_nxt;
    prod_r     <= prod_nxt;
    res_st_r   <= res_st_nxt;
    res_addr_r <= res_addr_nxt;
    res_slot_r <= res_slot_nxt;
    out_st_r   <= out_st_nxt;
    out_addr_r <= out_addr_nxt;
    out_slot_r <= out_slot_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {{(OUT_TDATA_W - ADDR_W - SLOT_W){1'b0}}, out_slot_r, out_addr_r};

  // the divider is never restarted while it iterates
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // a read-modify-write never reads and writes the same word in one cycle
  a_map_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("map read and write collide");

  // a quotient is only delivered while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider result not awaited");

endmodule

// File: hw/rtl/bba_bitmap.sv
// Used-bit map RAM: one write port, one registered read port.
module bba_bitmap #(
  parameter int WORDS = 32,
  parameter int WA_W  = 5
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [WA_W-1:0]           waddr,
  input  logic [bba_pkg::WORD_W-1:0] wdata,
  input  logic                      re,
  input  logic [WA_W-1:0]           raddr,
  output logic [bba_pkg::WORD_W-1:0] rdata
);
  import bba_pkg::*;

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/bba_div.sv
// Restoring divider, one quotient bit a cycle, for quotients below 2^CNT_W.
module bba_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bba_pkg::ADDR_W-1:0] dividend,
  input  logic [bba_pkg::SIZE_W-1:0] divisor,
  output logic                       busy,
  output logic                       done,
  output logic [bba_pkg::CNT_W-1:0]  quotient
);
  import bba_pkg::*;

  localparam int D_W    = SIZE_W + CNT_W - 1;
  localparam int STEP_W = $clog2(CNT_W + 1);

  logic [ADDR_W-1:0] rem_r, rem_nxt;
  logic [D_W-1:0]    dsh_r, dsh_nxt;
  logic [CNT_W-1:0]  quo_r, quo_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              ge;

  assign ge = rem_r >= ADDR_W'(dsh_r);

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = dividend;
      dsh_nxt  = D_W'(divisor) << (CNT_W - 1);
      quo_nxt  = '0;
      step_nxt = STEP_W'(CNT_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // take off the shifted divisor where it fits, shift in the bit
      if (ge) begin
        rem_nxt = rem_r - ADDR_W'(dsh_r);
      end
      quo_nxt  = {quo_r[CNT_W-2:0], ge};
      dsh_nxt  = dsh_r >> 1;
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: tb/sv/bitmap_buffer_allocator_unit_chk.sv
// Checker for the bitmap buffer allocator: mirrors the used map and compares every result.
module bitmap_buffer_allocator_unit_chk #(
  parameter int BUFFERS = bba_pkg::BUFFERS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [bba_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [bba_pkg::OP_W-1:0]        in_tuser,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [bba_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [bba_pkg::STAT_W-1:0]      out_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bba_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                              fail_count,
  output int                              replies_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] addr;
    logic [SLOT_W-1:0] slot;
  } alloc_reply_t;

  bit                slot_used [BUFFERS];
  logic              pool_on;
  logic [ADDR_W-1:0] pool_base;
  logic [31:0]       pool_stride;
  logic [CNT_W-1:0]  pool_count;
  logic [SIZE_W-1:0] pool_bytes;
  alloc_reply_t      replies_due [$];
  int                mismatches;

  initial begin
    fail_count = 0;
    replies_pending = 0;
    mismatches = 0;
  end

  // Work out the reply to one request and update the used map.
  function automatic alloc_reply_t serve_request(logic [OP_W-1:0] op, logic [SIZE_W-1:0] size,
                                                 logic [CNT_W-1:0] ridx, logic [CNT_W-1:0] rnum,
                                                 logic [ADDR_W-1:0] addr);
    alloc_reply_t r;
    int           live, per, lo, hi, idx, i;
    logic         fits;
    logic [63:0]  base64, stride64, addr64, last64, quot, div64;
    r = '0;
    live = (int'(pool_count) > BUFFERS) ? BUFFERS : int'(pool_count);
    fits = pool_on && (pool_bytes >= size);
    base64 = 64'(pool_base);
    stride64 = 64'(pool_stride);
    addr64 = 64'(addr);
    case (op) inside
      OP_ALLOC, OP_REGION: begin
        lo = 0;
        hi = live;
        if (size == '0) begin
          r.status = ST_ZERO;
        end else if (op == OP_REGION && ridx >= rnum) begin
          r.status = ST_REGION;
        end else if (!fits) begin
          r.status = ST_NOPOOL;
        end else if (op == OP_REGION && int'(rnum) > live) begin
          r.status = ST_REGION;
        end else begin
          if (op == OP_REGION) begin
            per = live / int'(rnum);
            lo = int'(ridx) * per;
            hi = lo + per;
          end
          idx = hi;
          // scan downwards so the lowest free slot wins
          for (i = hi - 1; i >= lo; i--) begin
            if (!slot_used[i]) idx = i;
          end
          if (idx >= hi) begin
            r.status = ST_FULL;
          end else begin
            slot_used[idx] = 1'b1;
            r.status = ST_OK;
            r.addr = ADDR_W'(base64 + 64'(idx) * stride64);
            r.slot = SLOT_W'(idx);
          end
        end
      end
      OP_FREE: begin
        if (addr == '0) begin
          r.status = ST_NULL;
        end else if (!pool_on || live == 0) begin
          r.status = ST_OUTSIDE;
        end else begin
          last64 = base64 + 64'(live - 1) * stride64;
          if (addr64 < base64 || addr64 > last64) begin
            r.status = ST_OUTSIDE;
          end else begin
            div64 = (stride64 == 0) ? 64'd1 : stride64;
            quot = (addr64 - base64) / div64;
            if (quot < BUFFERS) slot_used[quot] = 1'b0;
            r.status = ST_OK;
            r.slot = quot[SLOT_W-1:0];
          end
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_reply_t want, got;
    if (!rst_n) begin
      foreach (slot_used[k]) slot_used[k] = 1'b0;
      pool_on = 1'b0;
      pool_base = '0;
      pool_stride = 32'd1;
      pool_count = '0;
      pool_bytes = '0;
      replies_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLE: pool_on = cfg_wdata[0];
          REG_BASE:   pool_base = cfg_wdata[ADDR_W-1:0];
          REG_STRIDE: pool_stride = cfg_wdata[31:0];
          REG_COUNT:  pool_count = cfg_wdata[CNT_W-1:0];
          REG_BYTES:  pool_bytes = cfg_wdata[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        replies_due.push_back(serve_request(in_tuser, in_tdata[31:0], in_tdata[42:32],
                                            in_tdata[53:43], in_tdata[101:54]));
      end
      if (out_tvalid && out_tready) begin
        got.status = out_tuser;
        got.addr = out_tdata[47:0];
        got.slot = out_tdata[57:48];
        if (replies_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing pending: status %0d addr %h slot %0d",
                     $realtime, got.status, got.addr, got.slot);
        end else begin
          want = replies_due.pop_front();
          if (got.status !== want.status || got.addr !== want.addr || got.slot !== want.slot) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: expected status %0d addr %h slot %0d, got %0d %h %0d",
                       $realtime, want.status, want.addr, want.slot,
                       got.status, got.addr, got.slot);
          end
        end
      end
    end
    fail_count <= mismatches;
    replies_pending <= replies_due.size();
  end

endmodule

// File: tb/sv/bitmap_buffer_allocator_unit_tb.sv
// Stimulus and verdict for the bitmap buffer allocator unit.
module bitmap_buffer_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam logic [OP_W-1:0]      OP_SPARE   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 3'd7;
  localparam int                   HANG_LIMIT = 3000;
  localparam int                   HOLD_LEN   = 400;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]        in_tuser = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]      out_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  int                     fail_count;
  int                     replies_pending;

  bit tx_gap_en = 1'b1;
  bit rx_stall_en = 1'b1;
  bit hold_req = 1'b0;

  // pool settings as last written, used to aim the random requests
  logic [ADDR_W-1:0] set_base;
  logic [31:0]       set_stride;
  logic [CNT_W-1:0]  set_count;
  logic [SIZE_W-1:0] set_bytes;
  int                region_span;

  bitmap_buffer_allocator_unit dut (
    .clk, .rst_n, .in_tdata, .in_tuser, .in_tvalid, .in_tready,
    .out_tdata, .out_tuser, .out_tvalid, .out_tready,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  bitmap_buffer_allocator_unit_chk chk (
    .clk, .rst_n, .in_tdata, .in_tuser, .in_tvalid, .in_tready,
    .out_tdata, .out_tuser, .out_tvalid, .out_tready,
    .cfg_we, .cfg_index, .cfg_wdata, .fail_count, .replies_pending
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: short random stalls, and one long hold-off on request.
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req <= 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        out_tready <= 1'b1;
      end else if (rx_stall_en && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic set_pool(input logic en, input logic [ADDR_W-1:0] base,
                          input logic [31:0] stride, input logic [CNT_W-1:0] count,
                          input logic [SIZE_W-1:0] bytes);
    cfg_write(REG_ENABLE, {{(CFG_DATA_W-1){1'b0}}, en});
    cfg_write(REG_BASE, base);
    cfg_write(REG_STRIDE, {16'd0, stride});
    cfg_write(REG_COUNT, {37'd0, count});
    cfg_write(REG_BYTES, {16'd0, bytes});
    cfg_we <= 1'b0;
    set_base = base;
    set_stride = stride;
    set_count = count;
    set_bytes = bytes;
  endtask

  task automatic send_request(input logic [OP_W-1:0] op, input logic [SIZE_W-1:0] size,
                              input logic [CNT_W-1:0] ridx, input logic [CNT_W-1:0] rnum,
                              input logic [ADDR_W-1:0] addr);
    if (tx_gap_en && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {2'b00, addr, rnum, ridx, size};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (replies_pending != 0);
  endtask

  // Mostly well-aimed requests against the current pool, with some noise.
  task automatic send_random();
    logic [OP_W-1:0]   op;
    logic [SIZE_W-1:0] size;
    logic [CNT_W-1:0]  ridx, rnum;
    logic [ADDR_W-1:0] addr;
    int unsigned       live, pick, slot;
    live = (set_count > 1024) ? 1024 : 32'(set_count);
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0: size = '0;
      1: size = $urandom;
      2: size = set_bytes + 32'd1;
      default: size = (set_bytes == 0) ? 32'd1 : $urandom_range(1, set_bytes);
    endcase
    case ($urandom_range(0, 7))
      0: rnum = CNT_W'($urandom);
      1: rnum = '0;
      default: rnum = (live == 0) ? 11'd1 :
                      CNT_W'($urandom_range(1, (live < region_span) ? live : region_span));
    endcase
    if ($urandom_range(0, 7) == 0 || rnum == 0) ridx = CNT_W'($urandom);
    else ridx = CNT_W'($urandom_range(0, 32'(rnum) - 1));
    slot = (live == 0) ? 0 : $urandom_range(0, live - 1);
    addr = set_base + ADDR_W'(slot) * ADDR_W'(set_stride);
    case ($urandom_range(0, 9))
      0: addr = '0;
      1: addr = ADDR_W'({$urandom, $urandom});
      2: addr = set_base - 48'd1;
      3: if (set_stride > 1) addr = addr + ADDR_W'($urandom_range(1, set_stride - 1));
      default: ;
    endcase
    if (pick < 40) op = OP_ALLOC;
    else if (pick < 65) op = OP_REGION;
    else if (pick < 95) op = OP_FREE;
    else begin
      op = OP_SPARE;
      size = $urandom;
      ridx = CNT_W'($urandom);
      rnum = CNT_W'($urandom);
      addr = ADDR_W'({$urandom, $urandom});
    end
    send_request(op, size, ridx, rnum, addr);
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) send_random();
    wait_drained();
  endtask

  initial begin : stimulus
    logic [ADDR_W-1:0] b;
    region_span = 16;
    set_base = '0;
    set_stride = 32'd1;
    set_count = '0;
    set_bytes = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: pool disabled and empty
    send_request(OP_ALLOC, 32'd0, 11'd0, 11'd0, 48'd0);
    send_request(OP_ALLOC, 32'd5, 11'd0, 11'd0, 48'd0);
    send_request(OP_FREE, 32'd0, 11'd0, 11'd0, 48'd0);
    send_request(OP_FREE, 32'd0, 11'd0, 11'd0, 48'd5);
    send_request(OP_SPARE, '1, '1, '1, '1);
    wait_drained();

    // small pool: limits, regions, leftover buffers, frees at the edges
    b = 48'h1000;
    set_pool(1'b1, b, 32'd64, 11'd8, 32'd256);
    send_request(OP_ALLOC, 32'd256, 11'd0, 11'd0, 48'd0);
    send_request(OP_ALLOC, 32'd257, 11'd0, 11'd0, 48'd0);
    send_request(OP_ALLOC, '1, 11'd0, 11'd0, 48'd0);
    send_request(OP_REGION, 32'd1, 11'd0, 11'd0, 48'd0);
    send_request(OP_REGION, 32'd300, 11'd5, 11'd2, 48'd0);
    send_request(OP_REGION, 32'd300, 11'd0, 11'd2, 48'd0);
    send_request(OP_REGION, 32'd1, 11'd0, 11'd9, 48'd0);
    send_request(OP_REGION, 32'd0, 11'd0, 11'd0, 48'd0);
    send_request(OP_REGION, 32'd1, 11'd1, 11'd3, 48'd0);
    repeat (3) send_request(OP_REGION, 32'd1, 11'd2, 11'd3, 48'd0);
    repeat (5) send_request(OP_ALLOC, 32'd16, 11'd0, 11'd0, 48'd0);
    send_request(OP_FREE, 32'd0, 11'd0, 11'd0, b + 48'd192);
    send_request(OP_FREE, 32'd0, 11'd0, 11'd0, b + 48'd197);
    send_request(OP_FREE, 32'd0, 11'd0, 11'd0, b - 48'd1);
    send_request(OP_FREE, 32'd0, 11'd0, 11'd0, b + 48'd449);
    send_request(OP_FREE, 32'd0, 11'd0, 11'd0, b + 48'd448);
    send_request(OP_FREE, 32'd0, 11'd0, 11'd0, '1);
    wait_drained();

    set_pool(1'b1, ADDR_W'({$urandom, $urandom}), $urandom_range(1, 4096), 11'd20,
             $urandom_range(1, 65535));
    for (int i = 0; i < 40; i++) send_random();
    // hold the result side off and keep offering until the input backs up
    hold_req <= 1'b1;
    run_random(80);

    region_span = 1024;
    set_pool(1'b1, 48'd0, '1, 11'd1024, '1);
    run_random(80);

    region_span = 16;
    set_pool(1'b1, '1, 32'h1000, 11'd5, 32'd1);
    run_random(50);

    cfg_write(REG_SPARE, '1);
    set_pool(1'b1, ADDR_W'({$urandom, $urandom}), 32'd0, 11'd2047, 32'd64);
    run_random(60);

    set_pool(1'b0, 48'h4000, 32'd8, 11'd16, 32'd128);
    run_random(40);

    set_pool(1'b1, 48'h4000, 32'd8, 11'd0, 32'd128);
    run_random(30);

    set_pool(1'b1, ADDR_W'({$urandom, $urandom}), $urandom, CNT_W'($urandom_range(1, 64)),
             $urandom);
    for (int i = 0; i < 100; i++) send_random();
    tx_gap_en = 1'b0;
    rx_stall_en = 1'b0;
    run_random(90);

    repeat (64) @(posedge clk);
    if (fail_count == 0 && replies_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
